@@ rtl/core/ltf_pkg.sv @@
// Shared types, constants and helpers for the lapse-rate tropopause finder.
package ltf_pkg;

  localparam int MAX_LEVELS_DEF = 128;
  localparam int QDEPTH         = 2;
  localparam int DIV_QW         = 28;
  localparam int DIV_DW         = 32;
  localparam int LAPSE_SAT      = 8388607;
  localparam int HEIGHT_SAT     = 100000;
  localparam int EARTH_R        = 6378137;
  localparam int EARTH_R256     = 256 * EARTH_R;

  localparam logic [1:0] STAT_FOUND = 2'd0;
  localparam logic [1:0] STAT_COLD  = 2'd1;
  localparam logic [1:0] STAT_NONE  = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_BAND_LOW  = 2'd2;
  localparam logic [1:0] REG_BAND_HIGH = 2'd3;

  typedef struct packed {
    logic [16:0]        pressure;
    logic signed [17:0] altitude;
    logic [15:0]        temperature;
    logic               last_level;
  } item_t;

  typedef struct packed {
    logic [17:0]        psum;
    logic signed [18:0] asum;
    logic signed [23:0] lapse;
    logic [15:0]        temp;
    logic [16:0]        pres;
  } rec_t;

  typedef struct packed {
    logic signed [14:0] thr;
    logic [14:0]        win;
    logic [16:0]        plo;
    logic [16:0]        phi;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [4:0]        steps;
    logic [DIV_DW-1:0] rem_init;
    logic [DIV_QW-1:0] low;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LD_PREP, ST_LD_DIV, ST_LD_WR,
    ST_S_INIT, ST_S_RD, ST_S_CHK, ST_W_RD, ST_W_CHK, ST_W_END,
    ST_F_INIT, ST_F_RD, ST_F_CHK, ST_F_END,
    ST_K_RD, ST_K_RD2, ST_K_LAT,
    ST_I_MUL1, ST_I_MUL2, ST_I_SUM, ST_I_CMP, ST_I_TST,
    ST_I_DIV1, ST_I_MULR, ST_I_DIV2S, ST_I_DIV2, ST_DONE
  } state_t;

  // doubled pressure strictly inside the doubled band
  function automatic logic in_band(input logic [17:0] p2, input cfg_t c);
    return (p2 > {c.plo, 1'b0}) && (p2 < {c.phi, 1'b0});
  endfunction

endpackage

@@ rtl/core/ltf_front.sv @@
// Front end: takes level beats and holds them in a short queue.
module ltf_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ltf_pkg::item_t in_item,
  output logic           q_valid,
  output ltf_pkg::item_t q_item,
  input  logic           q_pop
);
  import ltf_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  item_t            slot [QDEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [PW:0]      fill;
  logic             push;

  assign busy    = (fill == (PW+1)'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign q_item  = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      if (q_pop) rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

endmodule

@@ rtl/core/ltf_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module ltf_div (
  input  logic              clk,
  input  logic              rst,
  input  ltf_pkg::div_req_t req,
  output ltf_pkg::div_rsp_t rsp
);
  import ltf_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_QW-1:0] q;
  logic [4:0]        left;
  logic              busy;
  logic [DIV_DW:0]   r2;
  logic              ge;

  assign r2      = {rem, q[DIV_QW-1]};
  assign ge      = (r2 >= {1'b0, req.divisor});
  assign rsp.quo = q;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      q   <= req.low;
    end else if (busy) begin
      rem <= ge ? DIV_DW'(r2 - {1'b0, req.divisor}) : r2[DIV_DW-1:0];
      q   <= {q[DIV_QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      left     <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= busy && (left == 5'd1);
      if (req.start) begin
        busy <= 1'b1;
        left <= req.steps;
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == 5'd1) busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/ltf_back.sv @@
// Back end: level store, lapse rates, tropopause search and height conversion.
module ltf_back #(
  parameter int MAX_LEVELS = ltf_pkg::MAX_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  ltf_pkg::item_t    item,
  output logic              item_pop,
  input  ltf_pkg::cfg_t     cfg,
  output ltf_pkg::div_req_t div_req,
  input  ltf_pkg::div_rsp_t div_rsp,
  output logic              res_valid,
  output logic [16:0]       res_height,
  output logic [1:0]        res_status
);
  import ltf_pkg::*;

  localparam int LCW = $clog2(MAX_LEVELS + 1);
  localparam int IW  = $clog2(MAX_LEVELS);

  state_t state, state_next;

  rec_t           mem [MAX_LEVELS];
  rec_t           rd_q, wr_rec;
  logic [IW-1:0]  rd_addr;
  logic           mem_we;

  item_t              it;
  logic [LCW-1:0]     cnt;
  logic [15:0]        warm;
  logic [16:0]        prev_p;
  logic signed [17:0] prev_alt;
  logic [15:0]        prev_t;
  logic signed [23:0] lapse;

  logic [LCW-1:0]     c, a, k, cold_lvl;
  logic signed [35:0] sum, tacc;
  logic               walked, cold_ok;
  logic signed [20:0] lim;
  logic [15:0]        cold;
  logic signed [23:0] lap_k, lap_k1;
  logic signed [18:0] s1, s2;
  logic signed [24:0] den;
  logic signed [44:0] prod1;
  logic signed [43:0] prod2;
  logic signed [45:0] nn;
  logic [25:0]        dd;
  logic [42:0]        hsat;
  logic [24:0]        h256;
  logic [47:0]        hr;
  logic [16:0]        z;
  logic [1:0]         status;

  // load datapath
  logic signed [16:0] dt;
  logic signed [18:0] dz;
  logic [16:0]        dt_abs;
  logic [18:0]        dz_abs;
  logic [27:0]        num_mag;
  logic               lap_neg, full;
  logic signed [23:0] lap_special, lap_div;
  logic [22:0]        qsat;

  assign dt      = $signed({1'b0, it.temperature}) - $signed({1'b0, prev_t});
  assign dz      = $signed({it.altitude[17], it.altitude}) - $signed({prev_alt[17], prev_alt});
  assign dt_abs  = dt[16] ? 17'(-dt) : dt;
  assign dz_abs  = dz[18] ? 19'(-dz) : dz;
  assign num_mag = 28'(dt_abs[15:0]) * 28'd2560;
  assign lap_neg = dt[16] ^ dz[18];
  assign full    = (cnt == LCW'(MAX_LEVELS));
  assign qsat    = (div_rsp.quo > 28'(LAPSE_SAT)) ? 23'(LAPSE_SAT) : div_rsp.quo[22:0];
  assign lap_div = lap_neg ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});

  always_comb begin
    if (dt > 17'sd0)      lap_special = 24'(LAPSE_SAT);
    else if (dt < 17'sd0) lap_special = -24'sd8388607;
    else                  lap_special = '0;
  end

  assign wr_rec.psum  = {1'b0, it.pressure} + {1'b0, prev_p};
  assign wr_rec.asum  = $signed({it.altitude[17], it.altitude})
                      + $signed({prev_alt[17], prev_alt});
  assign wr_rec.lapse = lapse;
  assign wr_rec.temp  = it.temperature;
  assign wr_rec.pres  = it.pressure;

  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt[IW-1:0]] <= wr_rec;
    rd_q <= mem[rd_addr];
  end

  // search datapath
  logic signed [23:0] thr24;
  logic signed [35:0] thr36, lap36;
  logic signed [20:0] asum21;
  logic               s_hit, w_top, w_more, w_pass, f_hit;
  logic [LCW:0]       a_inc;
  logic signed [19:0] ds;
  logic signed [24:0] tl;
  logic [23:0]        den_mag;
  logic signed [45:0] nn_raw;
  logic [52:0]        dvd_h;
  logic [30:0]        dmod;
  logic [49:0]        dvd_z;

  assign thr24  = 24'(cfg.thr);
  assign thr36  = 36'(cfg.thr);
  assign lap36  = 36'(rd_q.lapse);
  assign asum21 = 21'(rd_q.asum);
  assign s_hit  = in_band(rd_q.psum, cfg) && (rd_q.lapse > thr24);
  assign a_inc  = (LCW+1)'(a) + 1'b1;
  assign w_top  = (a_inc >= (LCW+1)'(cnt));
  assign w_more = (asum21 < lim);
  assign w_pass = walked && (sum >= tacc);
  assign f_hit  = in_band({rd_q.pres, 1'b0}, cfg) && (rd_q.temp < cold) && (rd_q.temp < warm);
  assign ds      = 20'(s2) - 20'(s1);
  assign tl      = 25'(cfg.thr) - 25'(lap_k1);
  assign den_mag = den[24] ? 24'(-den) : den[23:0];
  assign nn_raw  = 46'(prod1) + 46'(prod2);
  assign dvd_h   = 53'({nn[42:0], 9'b0}) + 53'(dd);
  assign dmod    = 31'(EARTH_R256) - 31'(h256);
  assign dvd_z   = 50'({hr, 1'b0}) + 50'(dmod);

  always_comb begin
    state_next       = state;
    item_pop         = 1'b0;
    mem_we           = 1'b0;
    rd_addr          = '0;
    div_req.start    = 1'b0;
    div_req.steps    = 5'd28;
    div_req.rem_init = '0;
    div_req.low      = num_mag;
    div_req.divisor  = 32'(dz_abs);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop   = 1'b1;
          state_next = ST_LD_PREP;
        end
      end
      ST_LD_PREP: begin
        if (full) state_next = it.last_level ? ST_S_INIT : ST_IDLE;
        else if (cnt == '0 || dz == '0) state_next = ST_LD_WR;
        else begin
          div_req.start = 1'b1;
          state_next    = ST_LD_DIV;
        end
      end
      ST_LD_DIV: if (div_rsp.done) state_next = ST_LD_WR;
      ST_LD_WR: begin
        mem_we     = 1'b1;
        state_next = it.last_level ? ST_S_INIT : ST_IDLE;
      end
      ST_S_INIT: state_next = ST_S_RD;
      ST_S_RD: begin
        rd_addr    = c[IW-1:0];
        state_next = (c >= cnt) ? ST_F_INIT : ST_S_CHK;
      end
      ST_S_CHK: state_next = s_hit ? ST_W_RD : ST_S_RD;
      ST_W_RD: begin
        rd_addr    = a_inc[IW-1:0];
        state_next = w_top ? ST_W_END : ST_W_CHK;
      end
      ST_W_CHK: state_next = w_more ? ST_W_RD : ST_W_END;
      ST_W_END: begin
        if (w_pass) state_next = (c < LCW'(2)) ? ST_F_INIT : ST_K_RD;
        else        state_next = ST_S_RD;
      end
      ST_F_INIT: state_next = ST_F_RD;
      ST_F_RD: begin
        rd_addr    = c[IW-1:0];
        state_next = (c >= cnt) ? ST_F_END : ST_F_CHK;
      end
      ST_F_CHK: state_next = ST_F_RD;
      ST_F_END: state_next = (!cold_ok || cold_lvl < LCW'(2)) ? ST_DONE : ST_K_RD;
      ST_K_RD: begin
        rd_addr    = k[IW-1:0];
        state_next = ST_K_RD2;
      end
      ST_K_RD2: begin
        rd_addr    = IW'(k - 1'b1);
        state_next = ST_K_LAT;
      end
      ST_K_LAT:  state_next = ST_I_MUL1;
      ST_I_MUL1: state_next = (den == '0) ? ST_DONE : ST_I_MUL2;
      ST_I_MUL2: state_next = ST_I_SUM;
      ST_I_SUM:  state_next = ST_I_CMP;
      ST_I_CMP:  state_next = ST_I_TST;
      ST_I_TST: begin
        if (nn <= 46'sd0 || nn >= $signed({3'b0, hsat})) state_next = ST_DONE;
        else begin
          div_req.start    = 1'b1;
          div_req.steps    = 5'd25;
          div_req.rem_init = 32'(dvd_h[52:25]);
          div_req.low      = {dvd_h[24:0], 3'b0};
          div_req.divisor  = 32'({dd, 1'b0});
          state_next       = ST_I_DIV1;
        end
      end
      ST_I_DIV1: begin
        div_req.divisor = 32'({dd, 1'b0});
        if (div_rsp.done) state_next = ST_I_MULR;
      end
      ST_I_MULR: state_next = ST_I_DIV2S;
      ST_I_DIV2S: begin
        div_req.start    = 1'b1;
        div_req.steps    = 5'd18;
        div_req.rem_init = dvd_z[49:18];
        div_req.low      = {dvd_z[17:0], 10'b0};
        div_req.divisor  = {dmod, 1'b0};
        state_next       = ST_I_DIV2;
      end
      ST_I_DIV2: begin
        div_req.divisor = {dmod, 1'b0};
        if (div_rsp.done) state_next = ST_DONE;
      end
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      warm <= '0;
    end else begin
      case (state)
        ST_LD_WR: begin
          cnt <= cnt + 1'b1;
          if (it.temperature > warm) warm <= it.temperature;
        end
        ST_DONE: begin
          cnt  <= '0;
          warm <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (item_valid) it <= item;
      ST_LD_PREP: begin
        if (cnt == '0)    lapse <= '0;
        else if (dz == '0) lapse <= lap_special;
      end
      ST_LD_DIV: if (div_rsp.done) lapse <= lap_div;
      ST_LD_WR: begin
        prev_p   <= it.pressure;
        prev_alt <= it.altitude;
        prev_t   <= it.temperature;
      end
      ST_S_INIT: c <= LCW'(1);
      ST_S_CHK: begin
        if (s_hit) begin
          lim    <= asum21 + $signed({5'b0, cfg.win, 1'b0});
          a      <= c;
          sum    <= '0;
          tacc   <= '0;
          walked <= 1'b0;
        end else c <= c + 1'b1;
      end
      ST_W_RD: if (!w_top) a <= a_inc[LCW-1:0];
      ST_W_CHK: begin
        sum    <= sum + lap36;
        tacc   <= tacc + thr36;
        walked <= 1'b1;
      end
      ST_W_END: begin
        if (w_pass) begin
          k      <= c;
          status <= STAT_FOUND;
        end else c <= c + 1'b1;
      end
      ST_F_INIT: begin
        cold    <= 16'hFFFF;
        cold_ok <= 1'b0;
        c       <= LCW'(1);
      end
      ST_F_CHK: begin
        if (f_hit) begin
          cold     <= rd_q.temp;
          cold_lvl <= c;
          cold_ok  <= 1'b1;
        end
        c <= c + 1'b1;
      end
      ST_F_END: begin
        if (!cold_ok || cold_lvl < LCW'(2)) begin
          z      <= '0;
          status <= STAT_NONE;
        end else begin
          k      <= cold_lvl;
          status <= STAT_COLD;
        end
      end
      ST_K_RD2: begin
        lap_k <= rd_q.lapse;
        s2    <= rd_q.asum;
      end
      ST_K_LAT: begin
        lap_k1 <= rd_q.lapse;
        s1     <= rd_q.asum;
        den    <= 25'(lap_k) - 25'(rd_q.lapse);
      end
      ST_I_MUL1: begin
        if (den == '0) begin
          z      <= '0;
          status <= STAT_NONE;
        end
        prod1 <= ds * tl;
      end
      ST_I_MUL2: prod2 <= s1 * den;
      ST_I_SUM: begin
        nn <= den[24] ? 46'(-nn_raw) : nn_raw;
        dd <= {den_mag, 1'b0};
      end
      ST_I_CMP: hsat <= 43'(dd) * 43'(HEIGHT_SAT);
      ST_I_TST: begin
        if (nn <= 46'sd0)                         z <= '0;
        else if (nn >= $signed({3'b0, hsat}))     z <= 17'(HEIGHT_SAT);
      end
      ST_I_DIV1: if (div_rsp.done) h256 <= div_rsp.quo[24:0];
      ST_I_MULR: hr <= 48'(h256) * 48'(EARTH_R);
      ST_I_DIV2: begin
        if (div_rsp.done)
          z <= (div_rsp.quo > 28'(HEIGHT_SAT)) ? 17'(HEIGHT_SAT) : div_rsp.quo[16:0];
      end
      default: ;
    endcase
  end

  assign res_valid  = (state == ST_DONE);
  assign res_height = z;
  assign res_status = status;

endmodule

@@ rtl/core/lapse_rate_tropopause_finder_unit.sv @@
// Top level of the lapse-rate tropopause finder.
//
// Load a profile one level per beat (start high while busy is low); the beat
// with last_level set ends the profile and, some time later, done pulses for
// one cycle with tropopause_height and status. The receiver cannot stall, so
// the result must be taken in that cycle. Levels go through a two-beat queue
// into the back end; each stored level after the first with a non-zero
// altitude step waits on the iterative divider that forms the layer lapse
// rate. The final level adds the search: memory reads over the candidate
// layers and their mean windows (up to about n*n/2 reads for n levels in the
// worst case), a coldest-level pass over the levels, then multiplies and two
// divides for the interpolated, geometric height. busy is high only while the
// queue is full. Levels past MAX_LEVELS are dropped. Registers must be
// written only while the block is idle; the block does not enforce it.
module lapse_rate_tropopause_finder_unit #(
  parameter int MAX_LEVELS = ltf_pkg::MAX_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [16:0] pressure,
  input  logic [17:0] altitude,
  input  logic [15:0] temperature,
  input  logic        last_level,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output logic        done,
  output logic [16:0] tropopause_height,
  output logic [1:0]  status
);
  import ltf_pkg::*;

  cfg_t     cfg;
  item_t    in_item, q_item;
  logic     q_valid, q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // register file, reset to the standard band and threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr <= -15'sd512;
      cfg.win <= 15'd2000;
      cfg.plo <= 17'd7500;
      cfg.phi <= 17'd45000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.thr <= cfg_data[14:0];
        REG_WINDOW:    cfg.win <= cfg_data[14:0];
        REG_BAND_LOW:  cfg.plo <= cfg_data;
        REG_BAND_HIGH: cfg.phi <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.pressure    = pressure;
  assign in_item.altitude    = altitude;
  assign in_item.temperature = temperature;
  assign in_item.last_level  = last_level;

  ltf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // one divider serves both the lapse rates and the height conversion
  ltf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ltf_back #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .item_pop   (q_pop),
    .cfg        (cfg),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .res_valid  (done),
    .res_height (tropopause_height),
    .res_status (status)
  );

endmodule

@@ tb/sv/tb_lapse_rate_tropopause_finder_unit.sv @@
// Testbench for the lapse-rate tropopause finder: directed and random profiles, self-checked.
`timescale 1ns / 100ps

module tb_lapse_rate_tropopause_finder_unit;
  import ltf_pkg::*;

  localparam int  LEVELS      = MAX_LEVELS_DEF;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  RAND_ITEMS  = 1150;
  // quiet time before a register write / before the verdict
  localparam int  SETTLE      = 200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [16:0] pressure;
  logic [17:0] altitude;
  logic [15:0] temperature;
  logic        last_level;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        done;
  logic [16:0] tropopause_height;
  logic [1:0]  status;

  lapse_rate_tropopause_finder_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pressure(pressure), .altitude(altitude), .temperature(temperature),
    .last_level(last_level), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .tropopause_height(tropopause_height),
    .status(status)
  );

  typedef struct {
    logic [16:0] height;
    logic [1:0]  stat;
  } trop_t;

  trop_t trop_q[$];     // expected profile results, oldest first
  int    err_cnt;
  int    cyc_cnt;
  int    sent_cnt;
  bit    no_idle;       // stretch with back-to-back beats

  // shadow of the registers
  longint thr_m;
  longint win_m;
  longint plo_m;
  longint phi_m;

  // shadow of the stored profile
  longint lvl_p[LEVELS];
  longint lvl_z[LEVELS];
  longint lvl_t[LEVELS];
  longint lvl_lr[LEVELS];
  int     lvl_n;
  longint warm_t;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("tb_lapse_rate_tropopause_finder_unit NOT OK");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cyc_cnt);
    err_cnt++;
  endtask

  // result checker: one beat per done strobe
  always @(posedge clk) begin
    trop_t e;
    if (!rst && done) begin
      if (trop_q.size() == 0) begin
        report("result with none expected", tropopause_height, -1);
      end else begin
        e = trop_q.pop_front();
        if (tropopause_height !== e.height) report("tropopause_height", tropopause_height, e.height);
        if (status !== e.stat) report("status", status, e.stat);
      end
    end
  end

  // ---------------- predictor ----------------

  function automatic longint layer_lapse(input longint dt, input longint dz);
    longint q;
    if (dz == 0) return dt > 0 ? LAPSE_SAT : (dt < 0 ? -LAPSE_SAT : 0);
    q = ((dt * 2560 < 0) ? -dt * 2560 : dt * 2560) / (dz < 0 ? -dz : dz);
    if ((dt * 2560 < 0) != (dz < 0)) q = -q;
    if (q > LAPSE_SAT) q = LAPSE_SAT;
    if (q < -LAPSE_SAT) q = -LAPSE_SAT;
    return q;
  endfunction

  function automatic bit band_hit(input longint p2);
    return p2 > 2 * plo_m && p2 < 2 * phi_m;
  endfunction

  function automatic longint round_div(input longint a, input longint b);
    return (2 * a + b) / (2 * b);
  endfunction

  // search, fallback, interpolation and height conversion on the final level
  function automatic trop_t find_tropopause();
    trop_t  r;
    int     c, k, a;
    bit     found, cold_ok;
    int     cold_lvl;
    longint cold_t, sum, cnt, lim, s1, s2, den, num, nn, dd, h256, z;
    found = 0;
    k = 0;
    for (c = 1; c < lvl_n && !found; c++) begin
      if (band_hit(lvl_p[c] + lvl_p[c-1]) && lvl_lr[c] > thr_m) begin
        lim = lvl_z[c] + lvl_z[c-1] + 2 * win_m;
        sum = 0;
        cnt = 0;
        a = c;
        // mean window walk, clamped at the top layer
        forever begin
          if (a + 1 >= lvl_n) break;
          a++;
          sum += lvl_lr[a];
          cnt++;
          if (!(lvl_z[a] + lvl_z[a-1] < lim)) break;
        end
        if (cnt > 0 && sum >= thr_m * cnt) begin
          found = 1;
          k = c;
        end
      end
    end
    r.stat = STAT_FOUND;
    r.height = '0;
    if (!found || k < 2) begin
      cold_t = 64'hFFFF;
      cold_ok = 0;
      cold_lvl = 0;
      for (c = 1; c < lvl_n; c++) begin
        if (band_hit(2 * lvl_p[c]) && lvl_t[c] < cold_t && lvl_t[c] < warm_t) begin
          cold_t = lvl_t[c];
          cold_lvl = c;
          cold_ok = 1;
        end
      end
      if (!cold_ok || cold_lvl < 2) begin
        r.stat = STAT_NONE;
        return r;
      end
      k = cold_lvl;
      r.stat = STAT_COLD;
    end
    den = lvl_lr[k] - lvl_lr[k-1];
    if (den == 0) begin
      r.stat = STAT_NONE;
      return r;
    end
    s1 = lvl_z[k-1] + lvl_z[k-2];
    s2 = lvl_z[k] + lvl_z[k-1];
    num = (s2 - s1) * (thr_m - lvl_lr[k-1]);
    nn = s1 * den + num;
    dd = 2 * den;
    if (dd < 0) begin
      nn = -nn;
      dd = -dd;
    end
    if (nn <= 0) begin
      z = 0;
    end else if (nn >= HEIGHT_SAT * dd) begin
      z = HEIGHT_SAT;
    end else begin
      h256 = round_div(nn * 256, dd);
      z = round_div(h256 * EARTH_R, 256 * longint'(EARTH_R) - h256);
      if (z > HEIGHT_SAT) z = HEIGHT_SAT;
    end
    r.height = z[16:0];
    return r;
  endfunction

  // fold one accepted level into the shadow profile
  task automatic absorb_level(input logic [16:0] p, input logic [17:0] zr,
                              input logic [15:0] t, input logic lst);
    longint z;
    z = longint'($signed(zr));
    if (lvl_n < LEVELS) begin
      lvl_p[lvl_n] = p;
      lvl_z[lvl_n] = z;
      lvl_t[lvl_n] = t;
      lvl_lr[lvl_n] = (lvl_n == 0) ? 0 : layer_lapse(longint'(t) - lvl_t[lvl_n-1],
                                                       z - lvl_z[lvl_n-1]);
      if (t > warm_t) warm_t = t;
      lvl_n++;
    end
    if (lst) begin
      trop_q.push_back(find_tropopause());
      lvl_n = 0;
      warm_t = 0;
    end
  endtask

  // ---------------- drivers ----------------

  task automatic send_level(input logic [16:0] p, input logic [17:0] z,
                            input logic [15:0] t, input logic lst);
    int gap;
    @(negedge clk);
    start = 1'b1;
    pressure = p;
    altitude = z;
    temperature = t;
    last_level = lst;
    do @(posedge clk); while (busy);
    absorb_level(p, z, t, lst);
    sent_cnt++;
    if (!no_idle && $urandom_range(99) < 11) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // block idle: every profile answered, then a quiet stretch
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (trop_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_THRESHOLD: thr_m = longint'($signed(val[14:0]));
      REG_WINDOW:    win_m = val[14:0];
      REG_BAND_LOW:  plo_m = val;
      default:       phi_m = val;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(input int thr, input int win, input int plo, input int phi);
    wait_idle();
    write_reg(REG_THRESHOLD, 17'(thr));
    write_reg(REG_WINDOW, 17'(win));
    write_reg(REG_BAND_LOW, 17'(plo));
    write_reg(REG_BAND_HIGH, 17'(phi));
  endtask

  // plausible sounding: lapse down to a random tropopause, then flat or warming
  task automatic send_sounding(input int nlev);
    int  p, z, t, dz, trop_z, i;
    p = $urandom_range(95000, 120000);
    z = $urandom_range(0, 1500) - 1000;
    t = $urandom_range(27000, 31000);
    trop_z = $urandom_range(6000, 18000);
    for (i = 0; i < nlev; i++) begin
      send_level(17'(p), 18'(z), 16'(t), i == nlev - 1);
      dz = ($urandom_range(99) < 4) ? 0 : $urandom_range(200, 2500);
      z += dz;
      p -= p * dz / 8000;
      if (p < 0) p = 0;
      if (z < trop_z) t -= (dz * $urandom_range(400, 950)) / 1000;
      else t += (dz * $urandom_range(0, 300)) / 1000 - $urandom_range(0, 40);
      t += $urandom_range(0, 60) - 30;
      if (t < 0) t = 0;
    end
  endtask

  // raw bits anywhere in the field ranges, including odd orderings
  task automatic send_noise(input int nlev);
    int i;
    for (i = 0; i < nlev; i++)
      send_level(17'($urandom), 18'($urandom), 16'($urandom), i == nlev - 1);
  endtask

  // ---------------- tests ----------------

  task automatic test_standard_sounding();
    send_level(17'd100000, 18'd0,     16'd28800, 1'b0);
    send_level(17'd80000,  18'd2000,  16'd27500, 1'b0);
    send_level(17'd60000,  18'd4000,  16'd26200, 1'b0);
    send_level(17'd40000,  18'd7000,  16'd24250, 1'b0);
    send_level(17'd25000,  18'd10000, 16'd22300, 1'b0);
    send_level(17'd15000,  18'd13000, 16'd22300, 1'b0);
    send_level(17'd10000,  18'd16000, 16'd22500, 1'b0);
    send_level(17'd7000,   18'd19000, 16'd23000, 1'b1);
  endtask

  // zero altitude step with rising, falling and unchanged temperature
  task automatic test_zero_step();
    send_level(17'd30000, 18'd500, 16'd29000, 1'b0);
    send_level(17'd29000, 18'd500, 16'd29500, 1'b0);
    send_level(17'd28000, 18'd500, 16'd29000, 1'b0);
    send_level(17'd27000, 18'd500, 16'd29000, 1'b1);
  endtask

  // field extremes and negative lapse saturation
  task automatic test_field_extremes();
    send_level(17'h1FFFF, 18'h20000, 16'h0000, 1'b0);
    send_level(17'h00000, 18'h1FFFF, 16'hFFFF, 1'b0);
    send_level(17'd20000, 18'h1FFFF, 16'h0000, 1'b0);
    send_level(17'd10000, 18'h20000, 16'hFFFF, 1'b1);
  endtask

  task automatic test_single_level();
    send_level(17'd20000, 18'd9000, 16'd22000, 1'b1);
  endtask

  // no lapse layer: fallback with equal lapse rates, a real fallback, none in band
  task automatic test_fallback_cases();
    set_regs(8191, 2000, 7500, 120000);
    send_level(17'd40000, 18'd0,    16'd30000, 1'b0);
    send_level(17'd35000, 18'd1000, 16'd29000, 1'b0);
    send_level(17'd30000, 18'd2000, 16'd28000, 1'b0);
    send_level(17'd25000, 18'd3000, 16'd27000, 1'b1);
    send_level(17'd40000, 18'd0,    16'd30000, 1'b0);
    send_level(17'd35000, 18'd1000, 16'd29000, 1'b0);
    send_level(17'd30000, 18'd2000, 16'd27500, 1'b0);
    send_level(17'd25000, 18'd3000, 16'd27800, 1'b1);
    send_level(17'd1000,  18'd0,    16'd30000, 1'b0);
    send_level(17'd900,   18'd1000, 16'd29000, 1'b1);
  endtask

  // more levels than the store holds; the final mark still ends the profile
  task automatic test_full_store();
    int i;
    set_regs(-512, 2000, 7500, 45000);
    for (i = 0; i < LEVELS + 4; i++)
      send_level(17'(110000 - i * 800), 18'(i * 150), 16'(29000 - i * 45), i == LEVELS + 3);
  endtask

  task automatic test_random_profiles();
    int phase, n;
    for (phase = 0; sent_cnt < RAND_ITEMS; phase++) begin
      case (phase % 6)
        0: set_regs(-512, 2000, 7500, 45000);
        1: set_regs(-8192, 0, 0, 120000);
        2: set_regs(8192, 20000, 120000, 0);
        3: set_regs(-16384, 32767, 0, 131071);
        4: set_regs(16383, 1, 131071, 131071);
        default: set_regs($urandom_range(2048) - 1024, $urandom_range(20000),
                          $urandom_range(5000, 20000), $urandom_range(30000, 60000));
      endcase
      no_idle = (phase == 2);
      repeat (6) begin
        n = ($urandom_range(99) < 3) ? $urandom_range(40, 130) : $urandom_range(2, 14);
        if ($urandom_range(99) < 85) send_sounding(n);
        else send_noise($urandom_range(1, 6));
      end
    end
    no_idle = 0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    pressure = '0;
    altitude = '0;
    temperature = '0;
    last_level = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    err_cnt = 0;
    cyc_cnt = 0;
    sent_cnt = 0;
    no_idle = 0;
    thr_m = -512;
    win_m = 2000;
    plo_m = 7500;
    phi_m = 45000;
    lvl_n = 0;
    warm_t = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_standard_sounding();
    test_zero_step();
    test_field_extremes();
    test_single_level();
    test_fallback_cases();
    test_full_store();
    test_random_profiles();

    wait_idle();
    if (err_cnt == 0) begin
      $display("tb_lapse_rate_tropopause_finder_unit OK");
    end else begin
      $display("tb_lapse_rate_tropopause_finder_unit NOT OK");
    end
    $finish;
  end

endmodule
